### src/slrac_pkg.sv
// package: shared types, constants and operation codes for the sparse layer core
package slrac_pkg;

    localparam int MAX_NEURONS_DEF  = 1024;
    localparam int MAX_BATCH_DEF    = 16;
    localparam int MAX_NONZEROS_DEF = 32768;
    localparam int LAYERS_DEF       = 4;

    localparam int OP_W   = 3;
    localparam int LAY_W  = 2;
    localparam int ROW_W  = 4;
    localparam int NIDX_W = 11;
    localparam int POS_W  = 15;
    localparam int RS_W   = 16;
    localparam int COL_W  = 10;
    localparam int WT_W   = 16;
    localparam int FEAT_W = 16;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 11;
    localparam int ACC_W  = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int IN_W   = 96;
    localparam int OUT_W  = 32;
    localparam int QDEPTH = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_ROW_START = 3'd0,
        OP_NONZERO   = 3'd1,
        OP_FEATURE   = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_COMPUTE   = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYER  = 2'd0,
        CFG_BIAS   = 2'd1,
        CFG_NEURON = 2'd2,
        CFG_BATCH  = 2'd3
    } t_cfg_idx;

    // one decoded command handed from front to back
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [LAY_W-1:0]  layer;
        logic [ROW_W-1:0]  batch_row;
        logic [NIDX_W-1:0] neuron_index;
        logic [POS_W-1:0]  position;
        logic [RS_W-1:0]   row_start;
        logic [COL_W-1:0]  column_index;
        logic [WT_W-1:0]   weight;
        logic [FEAT_W-1:0] feature;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RS0,
        ST_RS1,
        ST_WALK,
        ST_DRAIN,
        ST_BIAS,
        ST_OUT
    } t_state;

endpackage

### src/sparse_layer_relu_active_count_core.sv
// top level of the sparse layer engine with clipped relu and active counts
// a compute word passes through the row-start reads, the walk, the pipeline drain, the bias
// add and the output register before its result word; the back takes no further command
// until the walk, the drain and the held result are done; the queue holds four
// reset: synchronous active low; clears counts, queue and control, config to defaults
// stores are undefined until written
module sparse_layer_relu_active_count_core #(
    parameter int MAX_NEURONS  = slrac_pkg::MAX_NEURONS_DEF,
    parameter int MAX_BATCH    = slrac_pkg::MAX_BATCH_DEF,
    parameter int MAX_NONZEROS = slrac_pkg::MAX_NONZEROS_DEF,
    parameter int LAYERS       = slrac_pkg::LAYERS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // operation, layer, batch_row, neuron_index, position, row_start,
    // column_index, weight, feature (lowest first)
    input  logic [slrac_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_value, active_count (lowest first)
    output logic [slrac_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [slrac_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [slrac_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    logic [slrac_pkg::LAY_W-1:0]  r_layer_in_use;
    logic signed [15:0]           r_bias;
    logic [slrac_pkg::NIDX_W-1:0] r_neuron_count;
    logic [4:0]                   r_batch_rows;
    slrac_pkg::t_cmd in_cmd, q_cmd;
    logic q_valid, q_ready;
    logic [slrac_pkg::VAL_W-1:0] value;
    logic [slrac_pkg::CNT_W-1:0] count;

    // unpack the word, first field in the lowest bits
    assign in_cmd.op           = s_axis_tdata[2:0];
    assign in_cmd.layer        = s_axis_tdata[4:3];
    assign in_cmd.batch_row    = s_axis_tdata[8:5];
    assign in_cmd.neuron_index = s_axis_tdata[19:9];
    assign in_cmd.position     = s_axis_tdata[34:20];
    assign in_cmd.row_start    = s_axis_tdata[50:35];
    assign in_cmd.column_index = s_axis_tdata[60:51];
    assign in_cmd.weight       = s_axis_tdata[76:61];
    assign in_cmd.feature      = s_axis_tdata[92:77];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_in_use <= '0;
            r_bias         <= '0;
            r_neuron_count <= 11'd1024;
            r_batch_rows   <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slrac_pkg::CFG_LAYER:  r_layer_in_use <= i_cfg_data[1:0];
                slrac_pkg::CFG_BIAS:   r_bias         <= i_cfg_data;
                slrac_pkg::CFG_NEURON: r_neuron_count <= i_cfg_data[10:0];
                default:               r_batch_rows   <= i_cfg_data[4:0];
            endcase
        end
    end

    slrac_front #(
        .MAX_NEURONS(MAX_NEURONS), .MAX_BATCH(MAX_BATCH),
        .MAX_NONZEROS(MAX_NONZEROS), .LAYERS(LAYERS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(in_cmd),
        .i_neuron_count(r_neuron_count), .i_batch_rows(r_batch_rows),
        .i_layer_in_use(r_layer_in_use),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    slrac_back #(
        .MAX_NEURONS(MAX_NEURONS), .MAX_BATCH(MAX_BATCH),
        .MAX_NONZEROS(MAX_NONZEROS), .LAYERS(LAYERS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .i_layer_in_use(r_layer_in_use), .i_bias(r_bias),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_value(value), .o_count(count)
    );

    assign m_axis_tdata = {5'd0, count, value};
endmodule

### src/slrac_front.sv
// front: accepts words, drops unknown-code and out-of-range items, queues commands
module slrac_front #(
    parameter int MAX_NEURONS  = slrac_pkg::MAX_NEURONS_DEF,
    parameter int MAX_BATCH    = slrac_pkg::MAX_BATCH_DEF,
    parameter int MAX_NONZEROS = slrac_pkg::MAX_NONZEROS_DEF,
    parameter int LAYERS       = slrac_pkg::LAYERS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  slrac_pkg::t_cmd           i_cmd,
    input  logic [slrac_pkg::NIDX_W-1:0] i_neuron_count,
    input  logic [4:0]                i_batch_rows,
    input  logic [slrac_pkg::LAY_W-1:0] i_layer_in_use,
    output logic                      o_valid,
    input  logic                      i_ready,
    output slrac_pkg::t_cmd           o_cmd
);
    localparam int QD = slrac_pkg::QDEPTH;
    localparam int QA = $clog2(QD);

    slrac_pkg::t_cmd r_q [QD];
    logic [QA-1:0] r_wp, r_rp;
    logic [QA:0]   r_cnt;
    logic keep, push, pop;
    slrac_pkg::t_cmd c;

    assign c = i_cmd;

    // loads and computes out of range and unknown codes are dropped here
    always_comb begin
        keep = 1'b0;
        case (c.op)
            slrac_pkg::OP_ROW_START:
                keep = (32'(c.layer) < LAYERS) && (32'(c.neuron_index) <= MAX_NEURONS);
            slrac_pkg::OP_NONZERO:
                keep = (32'(c.layer) < LAYERS) && (32'(c.position) < MAX_NONZEROS);
            slrac_pkg::OP_FEATURE:
                keep = (32'(c.batch_row) < MAX_BATCH) && (32'(c.neuron_index) < MAX_NEURONS);
            slrac_pkg::OP_CLEAR:
                keep = 1'b1;
            slrac_pkg::OP_COMPUTE:
                keep = ({1'b0, c.batch_row} < i_batch_rows)
                    && (32'(c.batch_row) < MAX_BATCH)
                    && (c.neuron_index < i_neuron_count)
                    && (32'(c.neuron_index) < MAX_NEURONS)
                    && (32'(i_layer_in_use) < LAYERS);
            default: keep = 1'b0;
        endcase
    end

    assign o_ready = (r_cnt != (QA+1)'(QD));
    assign push    = i_valid && o_ready && keep;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= c;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QA+1)'(push) - (QA+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == (QA+1)'(QD) |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !pop) else $error("queue underflow");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 1'b1) else $error("count slip");
`endif
endmodule

### src/slrac_back.sv
// back: stores, multiply-accumulate walk, clipping and active counts
module slrac_back #(
    parameter int MAX_NEURONS  = slrac_pkg::MAX_NEURONS_DEF,
    parameter int MAX_BATCH    = slrac_pkg::MAX_BATCH_DEF,
    parameter int MAX_NONZEROS = slrac_pkg::MAX_NONZEROS_DEF,
    parameter int LAYERS       = slrac_pkg::LAYERS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  slrac_pkg::t_cmd            i_cmd,
    input  logic [slrac_pkg::LAY_W-1:0] i_layer_in_use,
    input  logic signed [15:0]         i_bias,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [slrac_pkg::VAL_W-1:0] o_value,
    output logic [slrac_pkg::CNT_W-1:0] o_count
);
    localparam int LA   = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int NA   = $clog2(MAX_NEURONS);
    localparam int BA   = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int PA   = $clog2(MAX_NONZEROS);
    localparam int RSD  = (MAX_NEURONS + 1) * LAYERS;
    localparam int RSA  = $clog2(RSD);
    localparam int NZD  = MAX_NONZEROS * LAYERS;
    localparam int NZA  = $clog2(NZD);
    localparam int FD   = MAX_NEURONS * MAX_BATCH;
    localparam int FA   = $clog2(FD);
    localparam int PW   = PA + 1;
    localparam int AW   = slrac_pkg::ACC_W;
    localparam int CW   = slrac_pkg::CNT_W;

    logic [slrac_pkg::RS_W-1:0]   m_rs  [RSD];
    logic [slrac_pkg::COL_W-1:0]  m_col [NZD];
    logic [slrac_pkg::WT_W-1:0]   m_wt  [NZD];
    logic [slrac_pkg::FEAT_W-1:0] m_ft  [FD];
    logic [CW-1:0] r_cnt [MAX_BATCH];

    slrac_pkg::t_state r_st, n_st;
    slrac_pkg::t_cmd   r_cmd;
    logic [RSA-1:0] rs_addr;
    logic [slrac_pkg::RS_W-1:0] r_rs_q;
    logic [PW-1:0]  r_p, r_end, n_p, n_end, clampv;
    logic [NZA-1:0] nz_addr;
    logic [slrac_pkg::COL_W-1:0] r_col_q;
    logic [slrac_pkg::WT_W-1:0]  r_wt_q, r_wt_d;
    logic r_nz_v, r_ft_v, r_col_ok;
    logic [slrac_pkg::FEAT_W-1:0] r_ft_q;
    logic signed [31:0] r_prod;
    logic r_prod_v;
    logic [AW-1:0] r_acc;
    logic [slrac_pkg::VAL_W-1:0] r_val;
    logic r_out_v;
    logic [CW-1:0] r_out_cnt;
    logic [slrac_pkg::VAL_W-1:0] val_c;
    logic take, rd_issue;
    logic [BA-1:0] row;
    logic [AW-1:0] sum;

    assign row  = r_cmd.batch_row[BA-1:0];
    assign take = i_valid && o_ready;
    assign o_ready = (r_st == slrac_pkg::ST_IDLE) && !r_out_v;

    // saturate a row bound to the store size
    assign clampv = (32'(r_rs_q) > MAX_NONZEROS) ? PW'(MAX_NONZEROS) : PW'(r_rs_q);

    // start slot is read while the word is taken, end slot in the cycle after
    always_comb begin
        if (r_st == slrac_pkg::ST_IDLE)
            rs_addr = RSA'(32'(i_layer_in_use) * (MAX_NEURONS + 1)
                           + 32'(i_cmd.neuron_index[NA-1:0]));
        else
            rs_addr = RSA'(32'(i_layer_in_use) * (MAX_NEURONS + 1)
                           + 32'(r_cmd.neuron_index[NA-1:0]) + 1);
    end

    assign rd_issue = (r_st == slrac_pkg::ST_WALK) && (r_p < r_end);
    assign nz_addr = NZA'(32'(i_layer_in_use) * MAX_NONZEROS + 32'(r_p[PA-1:0]));
    assign sum = r_acc;

    always_comb begin
        if (sum[AW-1]) val_c = '0;
        else if (sum > AW'(64'd32 << 22)) val_c = 16'd32768;
        else val_c = sum[27:12];
    end

    // next state
    always_comb begin
        n_st  = r_st;
        n_p   = r_p;
        n_end = r_end;
        unique case (r_st)
            slrac_pkg::ST_IDLE: if (take && i_cmd.op == slrac_pkg::OP_COMPUTE) n_st = slrac_pkg::ST_RS0;
            slrac_pkg::ST_RS0:  n_st = slrac_pkg::ST_RS1;
            slrac_pkg::ST_RS1: begin
                n_end = clampv;
                n_st  = slrac_pkg::ST_WALK;
            end
            slrac_pkg::ST_WALK: begin
                if (rd_issue) n_p = r_p + 1'b1;
                else n_st = slrac_pkg::ST_DRAIN;
            end
            slrac_pkg::ST_DRAIN:
                if (!r_nz_v && !r_ft_v && !r_prod_v) n_st = slrac_pkg::ST_BIAS;
            slrac_pkg::ST_BIAS: n_st = slrac_pkg::ST_OUT;
            slrac_pkg::ST_OUT:  n_st = slrac_pkg::ST_IDLE;
            default: n_st = slrac_pkg::ST_IDLE;
        endcase
        if (r_st == slrac_pkg::ST_RS0) n_p = clampv;
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (take && i_cmd.op == slrac_pkg::OP_ROW_START)
            m_rs[RSA'(32'(i_cmd.layer[LA-1:0]) * (MAX_NEURONS + 1)
                      + 32'(i_cmd.neuron_index))] <= i_cmd.row_start;
        if (take && i_cmd.op == slrac_pkg::OP_NONZERO) begin
            m_col[NZA'(32'(i_cmd.layer[LA-1:0]) * MAX_NONZEROS + 32'(i_cmd.position[PA-1:0]))]
                <= i_cmd.column_index;
            m_wt[NZA'(32'(i_cmd.layer[LA-1:0]) * MAX_NONZEROS + 32'(i_cmd.position[PA-1:0]))]
                <= i_cmd.weight;
        end
        if (take && i_cmd.op == slrac_pkg::OP_FEATURE)
            m_ft[FA'(32'(i_cmd.batch_row[BA-1:0]) * MAX_NEURONS
                     + 32'(i_cmd.neuron_index[NA-1:0]))] <= i_cmd.feature;
        r_rs_q <= m_rs[rs_addr];
        r_col_q <= m_col[nz_addr];
        r_wt_q  <= m_wt[nz_addr];
        r_ft_q  <= m_ft[FA'(32'(row) * MAX_NEURONS + 32'(r_col_q[NA-1:0]))];
    end

    // walk pipeline: address, column/weight read, feature read, multiply, add
    always_ff @(posedge i_clk) begin
        if (take) r_cmd <= i_cmd;
        r_wt_d   <= r_wt_q;
        r_col_ok <= (32'(r_col_q) < MAX_NEURONS);
        r_prod   <= $signed(r_wt_d) * $signed({16'd0, (r_col_ok ? r_ft_q : 16'd0)});
        if (!i_rst_n) begin
            r_st <= slrac_pkg::ST_IDLE;
            r_nz_v <= 1'b0;
            r_ft_v <= 1'b0;
            r_prod_v <= 1'b0;
            r_out_v <= 1'b0;
            for (int i = 0; i < MAX_BATCH; i++) r_cnt[i] <= '0;
        end else begin
            r_st  <= n_st;
            r_p   <= n_p;
            r_end <= n_end;
            r_nz_v <= rd_issue;
            r_ft_v <= r_nz_v;
            r_prod_v <= r_ft_v;
            if (r_st == slrac_pkg::ST_RS0) r_acc <= '0;
            else if (r_prod_v) r_acc <= r_acc + AW'(r_prod);
            else if (r_st == slrac_pkg::ST_BIAS)
                r_acc <= r_acc + AW'({{(AW-26){i_bias[15]}}, i_bias, 10'd0});
            if (take && i_cmd.op == slrac_pkg::OP_CLEAR)
                for (int i = 0; i < MAX_BATCH; i++) r_cnt[i] <= '0;
            if (r_st == slrac_pkg::ST_OUT) begin
                r_val <= val_c;
                if (val_c != '0 && r_cnt[row] < slrac_pkg::COUNT_MAX) begin
                    r_cnt[row] <= r_cnt[row] + 1'b1;
                    r_out_cnt  <= r_cnt[row] + 1'b1;
                end else begin
                    r_out_cnt <= r_cnt[row];
                end
                r_out_v <= 1'b1;
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_value = r_val;
    assign o_count = r_out_cnt;

`ifndef SYNTHESIS
    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_issue |=> r_p == $past(r_p) + 1'b1) else $error("walk step");
    a_bias_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == slrac_pkg::ST_BIAS |-> !r_prod_v) else $error("product after drain");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !i_ready |=> r_out_v && $stable(r_val)) else $error("result lost");
`endif
endmodule
